### sv/circle_canvas_painter_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the circle canvas painter
// Property wrappers for the checker file of the block.
// ---------------------------------------------------------------------------
`ifndef CIRCLE_CANVAS_PAINTER_ASSERT_SVH
`define CIRCLE_CANVAS_PAINTER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge
`define CCP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge
`define CCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/ccp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Circle canvas painter package
// Field widths, codes, defaults and the controller/datapath interface types.
// ---------------------------------------------------------------------------
package ccp_pkg;

   // Default sizes of the canvas store and the fixed-point format
   localparam int DEF_MAX_WIDTH  = 512;
   localparam int DEF_MAX_HEIGHT = 512;
   localparam int DEF_FRAC_BITS  = 8;

   // Field widths
   localparam int ACT_W    = 2;
   localparam int COORD_W  = 19;
   localparam int CHAR_W   = 8;
   localparam int PIX_W    = 9;
   localparam int STAT_W   = 2;
   localparam int CSR_W    = 10;
   localparam int CSR_IDX_W = 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] IDX_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] IDX_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] IDX_BG     = 2'd2;

   // Register reset values
   localparam logic [CSR_W-1:0]  RST_WIDTH  = 10'd512;
   localparam logic [CSR_W-1:0]  RST_HEIGHT = 10'd512;
   localparam logic [CHAR_W-1:0] RST_BG     = 8'd32;

   // Actions
   localparam logic [ACT_W-1:0] ACT_DRAW  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

   // Result status codes
   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_BAD_RAD = 2'd1;
   localparam logic [STAT_W-1:0] ST_OUTSIDE = 2'd2;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic rd;
      logic setup;
      logic scan_step;
      logic clr_step;
      logic push;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             radius_pos;
      logic             size_zero;
      logic             scan_last;
      logic             pipe_busy;
      logic             clr_last;
   } stat_type;

endpackage

### sv/ccp_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Circle canvas painter controller
// Sequences reset clearing, draw scans, reads, clears and the result beat.
// ---------------------------------------------------------------------------
module ccp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  ccp_pkg::stat_type  stat,
   output ccp_pkg::cmd_type   cmd
);

   localparam logic [3:0] S_INIT   = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_DECODE = 4'd2;
   localparam logic [3:0] S_SETUP  = 4'd3;
   localparam logic [3:0] S_SCAN   = 4'd4;
   localparam logic [3:0] S_DRAIN  = 4'd5;
   localparam logic [3:0] S_CLEAR  = 4'd6;
   localparam logic [3:0] S_FINISH = 4'd7;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_INIT: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            cmd.load = req_tvalid;
            if (req_tvalid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.action)
               ccp_pkg::ACT_DRAW: begin
                  if (!stat.radius_pos || stat.size_zero) begin
                     state_in = S_FINISH;
                  end else begin
                     state_in = S_SETUP;
                  end
               end
               ccp_pkg::ACT_READ: begin
                  cmd.rd   = 1'b1;
                  state_in = S_FINISH;
               end
               ccp_pkg::ACT_CLEAR: begin
                  state_in = S_CLEAR;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!stat.pipe_busy) begin
               state_in = S_FINISH;
            end
         end
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   // Hold the result beat until the sink takes it
   assign rsp_valid_in = cmd.push | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

### sv/ccp_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Circle canvas painter datapath
// Settings registers, item latch, scan pipeline, canvas stores and result.
// ---------------------------------------------------------------------------
module ccp_datapath #(
   parameter int MAX_WIDTH  = ccp_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = ccp_pkg::DEF_MAX_HEIGHT,
   parameter int FRAC_BITS  = ccp_pkg::DEF_FRAC_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ccp_pkg::cmd_type                   cmd,
   output ccp_pkg::stat_type                  stat,
   input  logic                               csr_we,
   input  logic [ccp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ccp_pkg::CSR_W-1:0]          csr_wdata,
   input  logic [ccp_pkg::ACT_W-1:0]          in_action,
   input  logic                               in_outline_only,
   input  logic signed [ccp_pkg::COORD_W-1:0] in_center_x,
   input  logic signed [ccp_pkg::COORD_W-1:0] in_center_y,
   input  logic signed [ccp_pkg::COORD_W-1:0] in_radius,
   input  logic [ccp_pkg::CHAR_W-1:0]         in_paint_char,
   input  logic [ccp_pkg::PIX_W-1:0]          in_pixel_x,
   input  logic [ccp_pkg::PIX_W-1:0]          in_pixel_y,
   output logic [ccp_pkg::STAT_W-1:0]         rsp_status,
   output logic [ccp_pkg::CHAR_W-1:0]         rsp_pixel_char
);

   localparam int CW    = ccp_pkg::COORD_W;
   localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int AW    = XW + YW;
   localparam int DEPTH = 1 << AW;
   localparam int ZXW   = $clog2(MAX_WIDTH + 1);
   localparam int ZYW   = $clog2(MAX_HEIGHT + 1);
   localparam int ZMW   = (ZXW > ZYW) ? ZXW : ZYW;
   localparam int ZW    = (ZMW > ccp_pkg::CSR_W) ? ZMW : ccp_pkg::CSR_W;
   localparam int PXW   = XW + FRAC_BITS;
   localparam int PYW   = YW + FRAC_BITS;
   localparam int PMW   = (PXW > PYW) ? PXW : PYW;
   localparam int SW    = (PMW + 1 > CW) ? PMW + 2 : CW + 1;
   localparam int MW    = SW - 1;
   localparam int QW    = 2 * MW;
   localparam int SQW   = QW + 1;
   localparam int RMW   = CW - 1;
   localparam int R2W   = 2 * RMW;

   // Settings registers
   logic [ccp_pkg::CSR_W-1:0]  width_ff;
   logic [ccp_pkg::CSR_W-1:0]  height_ff;
   logic [ccp_pkg::CHAR_W-1:0] bg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= ccp_pkg::RST_WIDTH;
         height_ff <= ccp_pkg::RST_HEIGHT;
         bg_ff     <= ccp_pkg::RST_BG;
      end else if (csr_we) begin
         case (csr_index)
            ccp_pkg::IDX_WIDTH:  width_ff  <= csr_wdata;
            ccp_pkg::IDX_HEIGHT: height_ff <= csr_wdata;
            ccp_pkg::IDX_BG:     bg_ff     <= csr_wdata[ccp_pkg::CHAR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Saturate the canvas size to the store size
   logic [ZW-1:0] width_ext;
   logic [ZW-1:0] height_ext;
   logic [ZW-1:0] used_w;
   logic [ZW-1:0] used_h;

   assign width_ext  = ZW'(width_ff);
   assign height_ext = ZW'(height_ff);
   assign used_w = (width_ext > ZW'(MAX_WIDTH)) ? ZW'(MAX_WIDTH) : width_ext;
   assign used_h = (height_ext > ZW'(MAX_HEIGHT)) ? ZW'(MAX_HEIGHT) : height_ext;

   // Item latch
   logic [ccp_pkg::ACT_W-1:0]  action_ff;
   logic                       ring_ff;
   logic signed [CW-1:0]       cx_ff;
   logic signed [CW-1:0]       cy_ff;
   logic signed [CW-1:0]       r_ff;
   logic [ccp_pkg::CHAR_W-1:0] paint_ff;
   logic [ccp_pkg::PIX_W-1:0]  px_ff;
   logic [ccp_pkg::PIX_W-1:0]  py_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= in_action;
         ring_ff   <= in_outline_only;
         cx_ff     <= in_center_x;
         cy_ff     <= in_center_y;
         r_ff      <= in_radius;
         paint_ff  <= in_paint_char;
         px_ff     <= in_pixel_x;
         py_ff     <= in_pixel_y;
      end
   end

   // Squared radius and squared inner radius, once per draw
   logic signed [CW:0] inner;
   logic               inner_nonneg;
   logic [RMW-1:0]     r_mag;
   logic [RMW-1:0]     inner_mag;
   logic [R2W-1:0]     r2_ff;
   logic [R2W-1:0]     in2_ff;
   logic               cut_ff;

   assign inner        = (CW + 1)'(r_ff) - ((CW + 1)'(1) << FRAC_BITS);
   assign inner_nonneg = ~inner[CW];
   assign r_mag        = r_ff[RMW-1:0];
   assign inner_mag    = inner[RMW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         r2_ff  <= R2W'(r_mag) * R2W'(r_mag);
         in2_ff <= inner_nonneg ? R2W'(inner_mag) * R2W'(inner_mag) : '0;
         cut_ff <= ring_ff & inner_nonneg;
      end
   end

   // Scan counters
   logic [XW-1:0] x_ff;
   logic [YW-1:0] y_ff;
   logic          x_last;
   logic          y_last;

   assign x_last = (ZW'(x_ff) + ZW'(1)) == used_w;
   assign y_last = (ZW'(y_ff) + ZW'(1)) == used_h;

   always_ff @(posedge clock) begin
      if (reset || cmd.setup) begin
         x_ff <= '0;
         y_ff <= '0;
      end else if (cmd.scan_step) begin
         if (x_last) begin
            x_ff <= '0;
            y_ff <= y_ff + YW'(1);
         end else begin
            x_ff <= x_ff + XW'(1);
         end
      end
   end

   // Stage one: distance magnitudes along each axis
   logic [PXW-1:0]       xpos;
   logic [PYW-1:0]       ypos;
   logic signed [SW-1:0] dx;
   logic signed [SW-1:0] dy;
   logic [MW-1:0]        dxa_in;
   logic [MW-1:0]        dya_in;
   logic [MW-1:0]        dxa_ff;
   logic [MW-1:0]        dya_ff;
   logic [AW-1:0]        addr1_ff;
   logic                 v1_ff;

   assign xpos   = PXW'(x_ff) << FRAC_BITS;
   assign ypos   = PYW'(y_ff) << FRAC_BITS;
   assign dx     = SW'($signed({1'b0, xpos})) - SW'(cx_ff);
   assign dy     = SW'($signed({1'b0, ypos})) - SW'(cy_ff);
   assign dxa_in = dx[SW-1] ? MW'(-dx) : dx[MW-1:0];
   assign dya_in = dy[SW-1] ? MW'(-dy) : dy[MW-1:0];

   always_ff @(posedge clock) begin
      dxa_ff   <= dxa_in;
      dya_ff   <= dya_in;
      addr1_ff <= {y_ff, x_ff};
   end

   // Stage two: squares
   logic [QW-1:0] dx2_ff;
   logic [QW-1:0] dy2_ff;
   logic [AW-1:0] addr2_ff;
   logic          v2_ff;

   always_ff @(posedge clock) begin
      dx2_ff   <= QW'(dxa_ff) * QW'(dxa_ff);
      dy2_ff   <= QW'(dya_ff) * QW'(dya_ff);
      addr2_ff <= addr1_ff;
   end

   // Advance the pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.scan_step;
         v2_ff <= v1_ff;
      end
   end

   // Stage three: coverage test, feeds the store write
   logic [SQW-1:0] d2;
   logic           in_disc;
   logic           in_hole;
   logic           wr_hit;

   assign d2      = SQW'(dx2_ff) + SQW'(dy2_ff);
   assign in_disc = d2 <= SQW'(r2_ff);
   assign in_hole = cut_ff & (d2 <= SQW'(in2_ff));
   assign wr_hit  = v2_ff & in_disc & ~in_hole;

   // Clear sweep address, wraps to zero after the last entry
   logic [AW-1:0] clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   // Canvas stores
   logic [ccp_pkg::CHAR_W-1:0] char_mem [DEPTH];
   logic                       mark_mem [DEPTH];
   logic [ccp_pkg::CHAR_W-1:0] char_rd_ff;
   logic                       mark_rd_ff;
   logic [AW-1:0]              rd_addr;

   assign rd_addr = {YW'(py_ff), XW'(px_ff)};

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         char_mem[addr2_ff] <= paint_ff;
      end
      if (cmd.rd) begin
         char_rd_ff <= char_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         mark_mem[clr_ff] <= 1'b0;
      end else if (wr_hit) begin
         mark_mem[addr2_ff] <= 1'b1;
      end
      if (cmd.rd) begin
         mark_rd_ff <= mark_mem[rd_addr];
      end
   end

   // Result of the current item
   logic                        outside;
   logic [ccp_pkg::STAT_W-1:0]  status_in;
   logic [ccp_pkg::CHAR_W-1:0]  pix_in;
   logic [ccp_pkg::STAT_W-1:0]  status_ff;
   logic [ccp_pkg::CHAR_W-1:0]  pix_ff;

   assign outside = (ZW'(px_ff) >= used_w) || (ZW'(py_ff) >= used_h);

   always_comb begin
      status_in = ccp_pkg::ST_OK;
      pix_in    = '0;
      case (action_ff)
         ccp_pkg::ACT_DRAW: begin
            if (!stat.radius_pos) begin
               status_in = ccp_pkg::ST_BAD_RAD;
            end
         end
         ccp_pkg::ACT_READ: begin
            if (outside) begin
               status_in = ccp_pkg::ST_OUTSIDE;
            end else begin
               pix_in = mark_rd_ff ? char_rd_ff : bg_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         status_ff <= status_in;
         pix_ff    <= pix_in;
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_pixel_char = pix_ff;

   // Status toward the controller
   assign stat.action     = action_ff;
   assign stat.radius_pos = ~r_ff[CW-1] & (r_ff != '0);
   assign stat.size_zero  = (used_w == '0) || (used_h == '0);
   assign stat.scan_last  = x_last & y_last;
   assign stat.pipe_busy  = v1_ff | v2_ff;
   assign stat.clr_last   = (clr_ff == AW'(DEPTH - 1));

endmodule

### sv/circle_canvas_painter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Circle canvas painter
// Character canvas that paints filled discs or rings, reads and clears pixels.
// ---------------------------------------------------------------------------
//  channel | direction | contents
//  req_    | in        | tuser action; tdata ring flag, centre, radius, char, pixel
//  rsp_    | out       | tuser status; tdata pixel char
//  csr_    | in        | write enable, register index, write data
//
//  A draw scans all canvas_width * canvas_height pixels: the scan pipeline
//  tests one pixel a cycle. A rejected draw or an unused action skips the scan.
//  A read goes through the registered read of the canvas stores.
//  A clear sweeps all 2^(XW+YW) store entries: one mark a cycle.
//  After reset the same clearing pass runs before req_tready.
//  One item is in work at a time; a result held on rsp_ does not block req_.
// ---------------------------------------------------------------------------
module circle_canvas_painter #(
   parameter int MAX_WIDTH  = ccp_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = ccp_pkg::DEF_MAX_HEIGHT,
   parameter int FRAC_BITS  = ccp_pkg::DEF_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // fields from bit 0: outline_only, center_x, center_y, radius,
   // paint_char, pixel_x, pixel_y, zero fill
   input  logic [87:0]                   req_tdata,
   // fields from bit 0: action
   input  logic [ccp_pkg::ACT_W-1:0]     req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // fields from bit 0: pixel_char
   output logic [ccp_pkg::CHAR_W-1:0]    rsp_tdata,
   // fields from bit 0: status
   output logic [ccp_pkg::STAT_W-1:0]    rsp_tuser,
   input  logic                          csr_we,
   input  logic [ccp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ccp_pkg::CSR_W-1:0]     csr_wdata
);

   ccp_pkg::cmd_type  cmd;
   ccp_pkg::stat_type stat;

   ccp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ccp_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .in_action       (req_tuser),
      .in_outline_only (req_tdata[0]),
      .in_center_x     ($signed(req_tdata[19:1])),
      .in_center_y     ($signed(req_tdata[38:20])),
      .in_radius       ($signed(req_tdata[57:39])),
      .in_paint_char   (req_tdata[65:58]),
      .in_pixel_x      (req_tdata[74:66]),
      .in_pixel_y      (req_tdata[83:75]),
      .rsp_status      (rsp_tuser),
      .rsp_pixel_char  (rsp_tdata)
   );

endmodule

### sv/ccp_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Circle canvas painter port checker
// Watches the top-level ports for result holding and item sequencing.
// ---------------------------------------------------------------------------
`include "circle_canvas_painter_assert.svh"

module ccp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [ccp_pkg::CHAR_W-1:0]    rsp_tdata,
   input logic [ccp_pkg::STAT_W-1:0]    rsp_tuser
);

   // A stalled result beat holds
   `CCP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser),
      "result beat changed while stalled")

   // One item in work at a time
   `CCP_ASSERT_NEXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready,
      "item accepted while another was in work")

   // A failed item carries no pixel character
   `CCP_ASSERT_SAME(a_err_zero, clock, reset, rsp_tvalid && (rsp_tuser != ccp_pkg::ST_OK),
      rsp_tdata == '0, "nonzero pixel with error status")

   // Reset leaves both channels quiet while the canvas is cleared
   `CCP_ASSERT_NEXT(a_rst_quiet, clock, 1'b0, reset, !req_tready && !rsp_tvalid,
      "channel active right after reset")

endmodule

bind circle_canvas_painter ccp_checker u_ccp_checker (.*);

### tb/sv/tb_circle_canvas_painter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the circle canvas painter
// Drives draw, read and clear beats over several canvas settings. A shadow
// canvas predicts every response. Both stream sides idle at random, and the
// response side holds off once for a long stretch.
// ---------------------------------------------------------------------------
module tb_circle_canvas_painter;

   import ccp_pkg::*;

   localparam int CLK_PERIOD      = 12;
   localparam int MAX_W           = DEF_MAX_WIDTH;
   localparam int MAX_H           = DEF_MAX_HEIGHT;
   localparam int FRAC            = DEF_FRAC_BITS;
   localparam int ONE             = 1 << FRAC;
   localparam int CELLS           = MAX_W * MAX_H;
   localparam int HOLD_OFF_CYCLES = 200;
   // a clear alone sweeps every store entry with no beat moving
   localparam int WATCHDOG_LIMIT  = 800_000;

   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

   // One request beat, unpacked
   typedef struct {
      bit [ACT_W-1:0]          action;
      bit                      ring;
      bit signed [COORD_W-1:0] cx;
      bit signed [COORD_W-1:0] cy;
      bit signed [COORD_W-1:0] rad;
      bit [CHAR_W-1:0]         ch;
      bit [PIX_W-1:0]          px;
      bit [PIX_W-1:0]          py;
   } paint_req_type;

   typedef struct {
      bit [STAT_W-1:0] status;
      bit [CHAR_W-1:0] pixel_char;
   } canvas_result_type;

   // Shadow canvas and queue of expected responses
   class canvas_scoreboard;
      bit [CSR_W-1:0]    width_reg;
      bit [CSR_W-1:0]    height_reg;
      bit [CHAR_W-1:0]   bg_reg;
      bit [CHAR_W-1:0]   glyph [CELLS];
      bit                inked [CELLS];
      canvas_result_type expected_q [$];
      int errors, draws, rejected, reads, outside, clears, settings;

      function new();
         width_reg  = RST_WIDTH;
         height_reg = RST_HEIGHT;
         bg_reg     = RST_BG;
         wipe();
      endfunction

      function void wipe();
         foreach (inked[i]) inked[i] = 1'b0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, bit [CSR_W-1:0] val);
         if (idx == IDX_WIDTH) width_reg = val;
         else if (idx == IDX_HEIGHT) height_reg = val;
         else if (idx == IDX_BG) bg_reg = val[CHAR_W-1:0];
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Apply one accepted request to the shadow canvas and queue its response
      function void note_request(paint_req_type it);
         canvas_result_type res;
         int     cols, rows, idx;
         longint one, ctr_x, ctr_y, r, inner, r2, in2, dx, dy, dy2, d2;
         bit     hit;
         res.status     = ST_OK;
         res.pixel_char = '0;
         cols = (width_reg > MAX_W) ? MAX_W : int'(width_reg);
         rows = (height_reg > MAX_H) ? MAX_H : int'(height_reg);
         case (it.action)
            ACT_DRAW: begin
               draws++;
               if (it.rad <= 0) begin
                  res.status = ST_BAD_RAD;
                  rejected++;
               end else begin
                  one   = longint'(1) << FRAC;
                  ctr_x = it.cx;
                  ctr_y = it.cy;
                  r     = it.rad;
                  inner = r - one;
                  r2    = r * r;
                  in2   = (inner >= 0) ? inner * inner : 0;
                  // scan every pixel in use, squared distances only
                  for (int y = 0; y < rows; y++) begin
                     dy  = y * one - ctr_y;
                     dy2 = dy * dy;
                     for (int x = 0; x < cols; x++) begin
                        dx  = x * one - ctr_x;
                        d2  = dy2 + dx * dx;
                        hit = (d2 <= r2);
                        // a ring drops pixels within radius - 1.0
                        if (hit && it.ring && inner >= 0 && d2 <= in2) hit = 1'b0;
                        if (hit) begin
                           glyph[y * MAX_W + x] = it.ch;
                           inked[y * MAX_W + x] = 1'b1;
                        end
                     end
                  end
               end
            end
            ACT_READ: begin
               reads++;
               if (it.px >= cols || it.py >= rows) begin
                  res.status = ST_OUTSIDE;
                  outside++;
               end else begin
                  idx = it.py * MAX_W + it.px;
                  res.pixel_char = inked[idx] ? glyph[idx] : bg_reg;
               end
            end
            ACT_CLEAR: begin
               clears++;
               wipe();
            end
            default: ;
         endcase
         expected_q.push_back(res);
      endfunction

      // Compare one accepted response with the oldest expectation
      function void check_response(bit [STAT_W-1:0] st, bit [CHAR_W-1:0] pc);
         canvas_result_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: response with nothing expected: status %0d pixel_char %0d",
                     $time, st, pc);
            return;
         end
         want = expected_q.pop_front();
         if (st != want.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, st);
         end
         if (pc != want.pixel_char) begin
            errors++;
            $display("%0t: pixel_char mismatch: expected %0d actual %0d",
                     $time, want.pixel_char, pc);
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [87:0]          req_tdata;
   logic [ACT_W-1:0]     req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [CHAR_W-1:0]    rsp_tdata;
   logic [STAT_W-1:0]    rsp_tuser;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   canvas_scoreboard sb;
   bit hold_off_ask = 1'b0;
   int feed_calm    = 0;
   int clears_left  = 0;
   int quiet_cycles = 0;

   circle_canvas_painter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Idle length: mostly none or short, a few long, and now and then a calm stretch
   function automatic int idle_len(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         calm = $urandom_range(15, 40);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(12, 40);
   endfunction

   function automatic paint_req_type mk_req(logic [ACT_W-1:0] act, bit ring, int cx, int cy,
                                            int rad, logic [CHAR_W-1:0] ch, int px, int py);
      paint_req_type it;
      it.action = act;
      it.ring   = ring;
      it.cx     = COORD_W'(cx);
      it.cy     = COORD_W'(cy);
      it.rad    = COORD_W'(rad);
      it.ch     = ch;
      it.px     = PIX_W'(px);
      it.py     = PIX_W'(py);
      return it;
   endfunction

   // Random request: mostly draws near the canvas and reads around it, some noise
   function automatic paint_req_type random_req(int cols, int rows, bit only_reads);
      paint_req_type it;
      int uw, uh, roll;
      uw = (cols > MAX_W) ? MAX_W : cols;
      uh = (rows > MAX_H) ? MAX_H : rows;
      it.action = ACT_W'($urandom_range(0, 3));
      it.ring   = 1'($urandom_range(0, 1));
      it.cx     = COORD_W'($urandom);
      it.cy     = COORD_W'($urandom);
      it.rad    = COORD_W'($urandom);
      it.ch     = CHAR_W'($urandom);
      it.px     = PIX_W'($urandom);
      it.py     = PIX_W'($urandom);
      roll = only_reads ? 50 : $urandom_range(0, 99);
      if (roll < 45) begin
         it.action = ACT_DRAW;
         it.cx = COORD_W'($urandom_range(0, (uw + 2) * ONE) - ONE);
         it.cy = COORD_W'($urandom_range(0, (uh + 2) * ONE) - ONE);
         if ($urandom_range(0, 3) == 0) it.rad = COORD_W'($urandom_range(1, 3 * ONE));
         else it.rad = COORD_W'($urandom_range(1, ((uw > uh ? uw : uh) + 1) * ONE));
      end else if (roll < 88) begin
         it.action = ACT_READ;
         it.px = PIX_W'($urandom_range(0, uw < 511 ? uw : 511));
         it.py = PIX_W'($urandom_range(0, uh < 511 ? uh : 511));
      end else if (roll < 90 && clears_left > 0) begin
         it.action = ACT_CLEAR;
         clears_left--;
      end else if (it.action == ACT_CLEAR) begin
         it.action = ACT_DRAW;
      end
      return it;
   endfunction

   // Offer one beat, hold it until accepted, then record it
   task automatic send_req(input paint_req_type it, input bit eager);
      int gap;
      gap = eager ? 0 : idle_len(feed_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.action;
      req_tdata  <= {4'b0, it.py, it.px, it.ch, it.rad, it.cy, it.cx, it.ring};
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_request(it);
   endtask

   // Drop valid and wait until every expected response has come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Write all three registers, one per cycle
   task automatic set_canvas(input int cols, input int rows, input int bg);
      csr_we    <= 1'b1;
      csr_index <= IDX_WIDTH;
      csr_wdata <= cols[CSR_W-1:0];
      @(posedge clock);
      csr_index <= IDX_HEIGHT;
      csr_wdata <= rows[CSR_W-1:0];
      @(posedge clock);
      csr_index <= IDX_BG;
      csr_wdata <= {2'b0, bg[CHAR_W-1:0]};
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_reg(IDX_WIDTH, cols[CSR_W-1:0]);
      sb.set_reg(IDX_HEIGHT, rows[CSR_W-1:0]);
      sb.set_reg(IDX_BG, {2'b0, bg[CHAR_W-1:0]});
      sb.settings++;
   endtask

   task automatic run_random_phase(input int n_items, input bit squeeze);
      int cols, rows, shape;
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
         // empty canvas: one side zero
         cols = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
         rows = (cols == 0) ? $urandom_range(1, 8) : 0;
      end else if (shape == 1) begin
         cols = $urandom_range(400, 1023);
         rows = $urandom_range(1, 2);
      end else if (shape == 2) begin
         cols = $urandom_range(1, 2);
         rows = $urandom_range(400, 1023);
      end else begin
         cols = $urandom_range(1, 24);
         rows = $urandom_range(1, 24);
      end
      wait_idle();
      set_canvas(cols, rows, $urandom_range(0, 255));
      if (squeeze) begin
         // hold the response side off and keep feeding reads back to back
         hold_off_ask = 1'b1;
         repeat (16) send_req(random_req(cols, rows, 1'b1), 1'b1);
      end
      repeat (n_items) send_req(random_req(cols, rows, 1'b0), 1'b0);
   endtask

   // Response side: random ready with a long hold on request
   initial begin : response_sink
      int gap, calm;
      gap  = 0;
      calm = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_ask) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_ask = 1'b0;
         end else if (gap > 0) begin
            rsp_tready <= 1'b0;
            gap--;
         end else begin
            rsp_tready <= 1'b1;
            gap = idle_len(calm);
         end
      end
   end

   // Check every accepted response beat
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
         sb.check_response(rsp_tuser, rsp_tdata);
   end

   // Watchdog: end the run when no beat moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
         $display("tb_circle_canvas_painter: errors");
         $finish;
      end
   end

   initial begin : stimulus
      sb = new();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_we     <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: full canvas, nothing painted yet
      send_req(mk_req(ACT_READ, 0, 0, 0, 0, 0, 0, 0), 1'b0);
      send_req(mk_req(ACT_READ, 0, 0, 0, 0, 0, 511, 511), 1'b0);
      send_req(mk_req(ACT_UNUSED, 1, -1, -1, -1, 8'hFF, 511, 511), 1'b0);

      // small canvas: disc, ring over it, rejected radii, tiny rings
      wait_idle();
      set_canvas(16, 12, ".");
      send_req(mk_req(ACT_DRAW, 0, 8 * ONE, 6 * ONE, 4 * ONE, "C", 0, 0), 1'b0);
      send_req(mk_req(ACT_DRAW, 1, 4 * ONE + ONE / 2, 3 * ONE + ONE / 4, 3 * ONE, "c", 0, 0),
               1'b0);
      send_req(mk_req(ACT_READ, 0, 0, 0, 0, 0, 8, 6), 1'b0);
      send_req(mk_req(ACT_DRAW, 0, 8 * ONE, 6 * ONE, 0, "x", 0, 0), 1'b0);
      send_req(mk_req(ACT_DRAW, 1, 8 * ONE, 6 * ONE, -262144, "x", 0, 0), 1'b0);
      send_req(mk_req(ACT_DRAW, 1, 15 * ONE, 11 * ONE, ONE / 2, 8'hFF, 0, 0), 1'b0);
      send_req(mk_req(ACT_DRAW, 1, 1 * ONE, 10 * ONE, ONE, 8'h00, 0, 0), 1'b0);
      send_req(mk_req(ACT_READ, 0, 0, 0, 0, 0, 15, 11), 1'b0);
      send_req(mk_req(ACT_READ, 0, 0, 0, 0, 0, 1, 10), 1'b0);
      send_req(mk_req(ACT_READ, 0, 0, 0, 0, 0, 16, 0), 1'b0);
      send_req(mk_req(ACT_READ, 0, 0, 0, 0, 0, 0, 12), 1'b0);
      // coordinate and radius extremes
      send_req(mk_req(ACT_DRAW, 0, 262143, -262144, 262143, "x", 0, 0), 1'b0);
      send_req(mk_req(ACT_DRAW, 1, -262144, 262143, 262143, "o", 0, 0), 1'b0);

      // new background shows at once, then clear
      wait_idle();
      set_canvas(16, 12, 255);
      send_req(mk_req(ACT_READ, 0, 0, 0, 0, 0, 0, 11), 1'b0);
      send_req(mk_req(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1'b0);
      send_req(mk_req(ACT_READ, 0, 0, 0, 0, 0, 8, 6), 1'b0);

      // empty canvas: nothing painted, every read outside
      wait_idle();
      set_canvas(0, 5, ".");
      send_req(mk_req(ACT_DRAW, 0, 0, 0, 4 * ONE, "C", 0, 0), 1'b0);
      send_req(mk_req(ACT_READ, 0, 0, 0, 0, 0, 0, 0), 1'b0);

      // oversized width saturates, one row
      wait_idle();
      set_canvas(1023, 1, "#");
      send_req(mk_req(ACT_DRAW, 1, 300 * ONE, 0, 40 * ONE, "c", 0, 0), 1'b0);
      send_req(mk_req(ACT_READ, 0, 0, 0, 0, 0, 260, 0), 1'b0);
      send_req(mk_req(ACT_READ, 0, 0, 0, 0, 0, 511, 0), 1'b0);

      // oversized height saturates, one column
      wait_idle();
      set_canvas(1, 1023, 0);
      send_req(mk_req(ACT_DRAW, 0, 0, 511 * ONE, 2 * ONE, "C", 0, 0), 1'b0);
      send_req(mk_req(ACT_READ, 0, 0, 0, 0, 0, 0, 511), 1'b0);

      // random phases, the first one under back-pressure; at most one more clear
      clears_left = 1;
      for (int ph = 0; ph < 6; ph++) run_random_phase((ph == 0) ? 8 : 10, ph == 0);

      wait_idle();
      repeat (32) @(posedge clock);
      $display("Covered %0d draws (%0d rejected), %0d reads (%0d outside), %0d clears",
               sb.draws, sb.rejected, sb.reads, sb.outside, sb.clears);
      $display("over %0d canvas settings, with random stalls on both sides and one long hold-off",
               sb.settings);
      if (sb.errors == 0)
         $display("tb_circle_canvas_painter: clean");
      else
         $display("tb_circle_canvas_painter: errors");
      $finish;
   end

endmodule
